/* rtl/core/swot_pkg.sv */
// ----------------------------------------------------------------------------
// swot_pkg: shared types and constants of the wall occlusion test core
// Sizes, command and wall entry formats, and the per-edge compare helpers.
// ----------------------------------------------------------------------------
package swot_pkg;

  localparam int MAX_WALLS   = 64;
  localparam int COORD_BITS  = 16;
  localparam int SIZE_W      = COORD_BITS - 1;
  localparam int WIDX_W      = 6;
  localparam int CFG_W       = 7;
  localparam int ADDR_W      = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int CNT_W       = $clog2(MAX_WALLS + 1);
  localparam int D_W         = COORD_BITS + 1;   // segment delta, far corner
  localparam int DIFF_W      = COORD_BITS + 2;   // viewer minus a corner coordinate
  localparam int PROD_W      = D_W + DIFF_W;
  localparam int K_W         = PROD_W + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] top;
    logic [SIZE_W-1:0]            width;
    logic [SIZE_W-1:0]            height;
  } wall_t;

  typedef struct packed {
    logic                         is_query;
    logic                         load_ok;
    logic [ADDR_W-1:0]            addr;
    wall_t                        wall;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [D_W-1:0]        dx;
    logic signed [D_W-1:0]        dy;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // True when n/d lies in [0, 1]; d is known to be nonzero by the caller.
  function automatic logic ratio_in_unit(input logic signed [DIFF_W-1:0] n,
                                         input logic signed [D_W-1:0] d);
    logic signed [DIFF_W-1:0] de;
    logic n_neg;
    logic n_zero;
    de     = DIFF_W'(d);
    n_neg  = n[DIFF_W-1];
    n_zero = (n == '0);
    if (!d[D_W-1]) begin
      return !n_neg && (n <= de);
    end
    return (n_neg || n_zero) && (n >= de);
  endfunction

  // The crossing along the edge is in [0, 1] when the cross products at both
  // ends of the edge have the signs that the sign of the denominator asks for.
  function automatic logic u_in_unit(input logic d_pos,
                                     input logic signed [K_W-1:0] k3,
                                     input logic signed [K_W-1:0] k4);
    logic ge3, le3, ge4, le4;
    ge3 = !k3[K_W-1];
    le3 = k3[K_W-1] || (k3 == '0);
    ge4 = !k4[K_W-1];
    le4 = k4[K_W-1] || (k4 == '0);
    return d_pos ? (ge3 && le4) : (le3 && ge4);
  endfunction

endpackage

/* rtl/core/swot_ram.sv */
// ----------------------------------------------------------------------------
// swot_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module swot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/swot_front.sv */
// ----------------------------------------------------------------------------
// swot_front: intake of the wall occlusion test core
// Decodes each item into a load or a query command and pushes it to the queue.
// ----------------------------------------------------------------------------
module swot_front (
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_op,
  input  logic [swot_pkg::WIDX_W-1:0]            in_wall_index,
  input  logic signed [swot_pkg::COORD_BITS-1:0] in_wall_left,
  input  logic signed [swot_pkg::COORD_BITS-1:0] in_wall_top,
  input  logic [swot_pkg::SIZE_W-1:0]            in_wall_width,
  input  logic [swot_pkg::SIZE_W-1:0]            in_wall_height,
  input  logic signed [swot_pkg::COORD_BITS-1:0] in_viewer_x,
  input  logic signed [swot_pkg::COORD_BITS-1:0] in_viewer_y,
  input  logic signed [swot_pkg::COORD_BITS-1:0] in_target_x,
  input  logic signed [swot_pkg::COORD_BITS-1:0] in_target_y,
  input  swot_pkg::q_stat_t                      q_stat,
  output logic                                   q_push,
  output swot_pkg::cmd_t                         q_cmd
);
  import swot_pkg::*;

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_cmd.is_query    = (op_t'(in_op) == OP_QUERY);
    // A load beyond the store depth is dropped by the back end.
    q_cmd.load_ok     = (32'(in_wall_index) < 32'(MAX_WALLS));
    q_cmd.addr        = ADDR_W'(in_wall_index);
    q_cmd.wall.left   = in_wall_left;
    q_cmd.wall.top    = in_wall_top;
    q_cmd.wall.width  = in_wall_width;
    q_cmd.wall.height = in_wall_height;
    q_cmd.x1          = in_viewer_x;
    q_cmd.y1          = in_viewer_y;
    q_cmd.dx          = D_W'(in_viewer_x) - D_W'(in_target_x);
    q_cmd.dy          = D_W'(in_viewer_y) - D_W'(in_target_y);
  end

endmodule

/* rtl/core/swot_queue.sv */
// ----------------------------------------------------------------------------
// swot_queue: short command queue between intake and execution
// Register-based FIFO that lets the two sides stall independently.
// ----------------------------------------------------------------------------
module swot_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  swot_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output swot_pkg::cmd_t    head,
  output swot_pkg::q_stat_t stat
);
  import swot_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wptr_nxt  = push ? (wptr_r + QPTR_W'(1)) : wptr_r;
    rptr_nxt  = pop  ? (rptr_r + QPTR_W'(1)) : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

  assign head       = mem_r[rptr_r];
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

/* rtl/core/swot_back.sv */
// ----------------------------------------------------------------------------
// swot_back: execution side of the wall occlusion test core
// Writes wall entries and scans the store for queries, one wall per cycle,
// through a three-stage edge test pipeline.
// ----------------------------------------------------------------------------
module swot_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [swot_pkg::CFG_W-1:0]  cfg_wall_count,
  input  swot_pkg::cmd_t              q_head,
  input  swot_pkg::q_stat_t           q_stat,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_visible
);
  import swot_pkg::*;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] wall_count_r;
  logic [CNT_W-1:0] n_cap;
  logic [CNT_W-1:0] cnt_r;
  logic             last_issue;

  // FSM outputs
  logic ram_we, ram_re, start_q, out_load;

  // Query operands, held for the whole scan
  logic signed [COORD_BITS-1:0] x1_r, y1_r;
  logic signed [D_W-1:0]        dx_r, dy_r;

  logic [$bits(wall_t)-1:0] ram_rdata;
  wall_t                    rd;

  // Stage 1: corner differences
  logic                      v1_r, v2_r, v3_r;
  logic signed [D_W-1:0]     r_s1, b_s1;
  logic signed [DIFF_W-1:0]  xl_r, xr_r, yt_r, yb_r;
  logic                      w_nz_r, h_nz_r;

  // Stage 2: products and the edge-side ratio tests
  logic signed [PROD_W-1:0]  a_r, b_r, c_r, e_r;
  logic                      ok_h_r, ok_v_r;
  logic                      tt_r, tr_r, tb_r, tl_r;

  // Stage 3: corner cross products
  logic signed [K_W-1:0]     k_lt, k_rt, k_rb, k_lb;
  logic                      dx_neg, dy_neg;
  logic                      hit;
  logic                      blocked_r;

  logic                      out_valid_r, out_visible_r;

  always_comb begin
    if (32'(wall_count_r) > 32'(MAX_WALLS)) begin
      n_cap = CNT_W'(MAX_WALLS);
    end else begin
      n_cap = CNT_W'(wall_count_r);
    end
  end

  assign last_issue = ((cnt_r + CNT_W'(1)) == n_cap);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty && q_head.is_query && !out_valid_r) begin
          state_nxt = (n_cap == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r && !v3_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // FSM outputs
  always_comb begin
    q_pop    = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    start_q  = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty && !q_head.is_query) begin
          q_pop  = 1'b1;
          ram_we = q_head.load_ok;
        end else if (!q_stat.empty && !out_valid_r) begin
          q_pop   = 1'b1;
          start_q = 1'b1;
        end
      end
      ST_SCAN: begin
        ram_re = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_DONE: begin
        out_load = 1'b1;
      end
    endcase
  end

  swot_ram #(
    .WIDTH ($bits(wall_t)),
    .DEPTH (MAX_WALLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_head.addr),
    .wdata (q_head.wall),
    .re    (ram_re),
    .raddr (cnt_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd = wall_t'(ram_rdata);

  always_comb begin
    r_s1 = D_W'(rd.left) + D_W'(rd.width);
    b_s1 = D_W'(rd.top) + D_W'(rd.height);
  end

  assign dx_neg = dx_r[D_W-1];
  assign dy_neg = dy_r[D_W-1];

  always_comb begin
    k_lt = K_W'(a_r) - K_W'(c_r);
    k_rt = K_W'(b_r) - K_W'(c_r);
    k_rb = K_W'(b_r) - K_W'(e_r);
    k_lb = K_W'(a_r) - K_W'(e_r);
    // Top, right, bottom and left edges in that order.
    hit = (ok_h_r && tt_r && u_in_unit(!dy_neg, k_lt, k_rt)) ||
          (ok_v_r && tr_r && u_in_unit(dx_neg, k_rt, k_rb)) ||
          (ok_h_r && tb_r && u_in_unit(dy_neg, k_rb, k_lb)) ||
          (ok_v_r && tl_r && u_in_unit(dx_neg, k_lt, k_lb));
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      wall_count_r  <= '0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      v3_r          <= 1'b0;
      out_valid_r   <= 1'b0;
      blocked_r     <= 1'b0;
      cnt_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        wall_count_r <= cfg_wall_count;
      end
      v1_r <= ram_re;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (start_q) begin
        cnt_r <= '0;
      end else if (ram_re) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (start_q) begin
        blocked_r <= 1'b0;
      end else if (v3_r && hit) begin
        blocked_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start_q) begin
      x1_r <= q_head.x1;
      y1_r <= q_head.y1;
      dx_r <= q_head.dx;
      dy_r <= q_head.dy;
    end
    if (out_load) begin
      out_visible_r <= !blocked_r;
    end
    xl_r   <= DIFF_W'(x1_r) - DIFF_W'(rd.left);
    xr_r   <= DIFF_W'(x1_r) - DIFF_W'(r_s1);
    yt_r   <= DIFF_W'(y1_r) - DIFF_W'(rd.top);
    yb_r   <= DIFF_W'(y1_r) - DIFF_W'(b_s1);
    w_nz_r <= (rd.width != '0);
    h_nz_r <= (rd.height != '0);
    a_r    <= PROD_W'(dy_r) * PROD_W'(xl_r);
    b_r    <= PROD_W'(dy_r) * PROD_W'(xr_r);
    c_r    <= PROD_W'(dx_r) * PROD_W'(yt_r);
    e_r    <= PROD_W'(dx_r) * PROD_W'(yb_r);
    // An edge parallel to the segment has a zero denominator and never blocks.
    ok_h_r <= (dy_r != '0) && w_nz_r;
    ok_v_r <= (dx_r != '0) && h_nz_r;
    tt_r   <= ratio_in_unit(yt_r, dy_r);
    tb_r   <= ratio_in_unit(yb_r, dy_r);
    tr_r   <= ratio_in_unit(xr_r, dx_r);
    tl_r   <= ratio_in_unit(xl_r, dx_r);
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

endmodule

/* rtl/core/segment_wall_occlusion_test_core.sv */
// ----------------------------------------------------------------------------
// segment_wall_occlusion_test_core: segment against wall rectangles test
// Stores up to MAX_WALLS wall rectangles and reports whether the segment from
// a viewer to a target crosses any edge of the first wall_count walls.
//
//   channel  signals                      direction  contents
//   in       in_valid / in_ready          input      load or query item
//   out      out_valid / out_ready        output     visible, one per query
//   cfg      cfg_valid / cfg_ready        input      wall_count register
//
// A load is written by the back end from its idle state. A query, with n the
// wall_count capped at MAX_WALLS, starts from the idle state, scans n walls at
// one wall per cycle through the single store read port, drains the store read
// and the edge test stages and then loads the result; when n is zero it skips
// the scan and drain. Reset is synchronous and active low; the store is not cleared.
// The intake keeps accepting into a two-item queue while the back end is busy
// or its result waits; a query starts only once the previous result is taken.
// ----------------------------------------------------------------------------
module segment_wall_occlusion_test_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_op,
  input  logic [swot_pkg::WIDX_W-1:0]            in_wall_index,
  input  logic signed [swot_pkg::COORD_BITS-1:0] in_wall_left,
  input  logic signed [swot_pkg::COORD_BITS-1:0] in_wall_top,
  input  logic [swot_pkg::SIZE_W-1:0]            in_wall_width,
  input  logic [swot_pkg::SIZE_W-1:0]            in_wall_height,
  input  logic signed [swot_pkg::COORD_BITS-1:0] in_viewer_x,
  input  logic signed [swot_pkg::COORD_BITS-1:0] in_viewer_y,
  input  logic signed [swot_pkg::COORD_BITS-1:0] in_target_x,
  input  logic signed [swot_pkg::COORD_BITS-1:0] in_target_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_visible,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [swot_pkg::CFG_W-1:0]             cfg_wall_count
);
  import swot_pkg::*;

  q_stat_t q_stat;
  cmd_t    q_cmd;
  cmd_t    q_head;
  logic    q_push;
  logic    q_pop;

  assign cfg_ready = 1'b1;

  swot_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_wall_index  (in_wall_index),
    .in_wall_left   (in_wall_left),
    .in_wall_top    (in_wall_top),
    .in_wall_width  (in_wall_width),
    .in_wall_height (in_wall_height),
    .in_viewer_x    (in_viewer_x),
    .in_viewer_y    (in_viewer_y),
    .in_target_x    (in_target_x),
    .in_target_y    (in_target_y),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_cmd          (q_cmd)
  );

  swot_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  swot_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_wall_count (cfg_wall_count),
    .q_head         (q_head),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_visible    (out_visible)
  );

endmodule

/* rtl/core/swot_checker.sv */
// ----------------------------------------------------------------------------
// swot_checker: port-level checks for the wall occlusion test core
// Watches reset behavior and the result channel; bound to the top level.
// ----------------------------------------------------------------------------
module swot_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_visible
);

  // Reset leaves no result pending.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  // Reset empties the queue, so the intake is open afterwards.
  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("intake closed right after reset");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_visible))
    else $error("stalled result changed or dropped");

endmodule

bind segment_wall_occlusion_test_core swot_checker u_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_visible (out_visible)
);
